>>> hw/rtl/spcp_pkg.sv
// ----------------------------------------------------------------------------
// spcp_pkg
// Shared types and constants for the smoothed constant-power panner.
// ----------------------------------------------------------------------------
package spcp_pkg;

  // configuration register indexes
  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] REG_TARGET = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_RAMP   = 2'd1;
  localparam int CFG_DATA_W = 16;

  localparam logic [15:0]        RAMP_RESET = 16'd2205;
  localparam logic signed [15:0] TARGET_MIN = -16'sd32767;

  // pi/2 in Q30, used to build the quarter-wave gain table
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // step divider: 32-bit magnitude, one quotient bit per cycle
  localparam int DIV_STEPS = 32;
  localparam int DIV_CNT_W = 5;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  // per-stage load enables of a gain lane
  typedef struct packed {
    logic en_rom;
    logic en_mul;
    logic en_out;
  } lane_ctrl_t;

endpackage

>>> hw/rtl/spcp_if.sv
// ----------------------------------------------------------------------------
// spcp_in_if / spcp_out_if
// Valid/ready stereo sample channels.
// ----------------------------------------------------------------------------
interface spcp_in_if #(
  parameter int SAMPLE_WIDTH = 24
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] left_in;
  logic signed [SAMPLE_WIDTH-1:0] right_in;

  modport source (output valid, left_in, right_in, input ready);
  modport sink   (input valid, left_in, right_in, output ready);
endinterface

interface spcp_out_if #(
  parameter int SAMPLE_WIDTH = 24
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] left_out;
  logic signed [SAMPLE_WIDTH-1:0] right_out;

  modport source (output valid, left_out, right_out, input ready);
  modport sink   (input valid, left_out, right_out, output ready);
endinterface

>>> hw/rtl/smoothed_constant_power_panner_unit.sv
// ----------------------------------------------------------------------------
// smoothed_constant_power_panner_unit
// Sine/cosine constant-power stereo panner with a linear position glide.
// ----------------------------------------------------------------------------
//   channel  direction  handshake         payload
//   in_ch    sink       valid/ready       left_in, right_in
//   out_ch   source     valid/ready       left_out, right_out
//   cfg_*    write      cfg_we            cfg_index, cfg_wdata
//
// One stereo item per cycle unless back-pressure or the divider stalls in_ch.
// Pipeline: pan update, table index multiply, table read, gain multiply,
// round/saturate; a stage advances whenever the stage after it is free.
// A target write that starts a glide runs the step divider, one quotient
// bit per cycle; in_ch.ready stays low until it finishes.
// rst_n is synchronous; it clears valids, pan state and the divider.
// ----------------------------------------------------------------------------
module smoothed_constant_power_panner_unit #(
  parameter int SAMPLE_WIDTH     = 24,
  parameter int GAIN_TABLE_DEPTH = 1024,
  parameter int GAIN_WIDTH       = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  spcp_in_if.sink                               in_ch,
  spcp_out_if.source                            out_ch,
  input  logic                                  cfg_we,
  input  logic [spcp_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [spcp_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

  localparam int IDX_W = $clog2(GAIN_TABLE_DEPTH + 1);
  localparam int MW    = 32 + IDX_W;

  // pan state
  logic signed [31:0] cur_pan_r;
  logic signed [31:0] pan_step_r;
  logic        [15:0] steps_left_r;
  logic signed [15:0] target_r;
  logic        [15:0] ramp_r;

  // pipeline valids and payload
  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic adv1, adv2, adv3, adv4, adv5;
  logic signed [31:0]             pan_s1_r;
  logic signed [SAMPLE_WIDTH-1:0] l_s1_r, r_s1_r, l_s2_r, r_s2_r;
  logic [IDX_W-1:0]               idx_s2_r;

  logic               in_fire;
  logic signed [31:0] pan_nxt;
  logic [31:0]        pan_u;
  logic [MW-1:0]      idx_prod;
  logic [IDX_W-1:0]   idx_raw;
  logic [IDX_W-1:0]   idx_nxt;
  logic [IDX_W-1:0]   addr_l;

  // configuration
  logic signed [15:0] cfg_t;
  logic signed [33:0] diff;
  logic               div_start;
  logic               div_abort;
  spcp_pkg::div_status_t div_st;
  logic signed [31:0] div_q;

  spcp_pkg::lane_ctrl_t lane_ctrl;

  assign adv5 = !v5_r || out_ch.ready;
  assign adv4 = !v4_r || adv5;
  assign adv3 = !v3_r || adv4;
  assign adv2 = !v2_r || adv3;
  assign adv1 = !v1_r || adv2;

  assign in_ch.ready = adv1 && !div_st.busy && !div_st.done;
  assign in_fire     = in_ch.valid && in_ch.ready;

  // position the item sees, after this sample's glide step
  always_comb begin
    pan_nxt = cur_pan_r;
    if (steps_left_r != '0) begin
      if (steps_left_r == 16'd1) pan_nxt = {target_r, 16'h0000};
      else                       pan_nxt = cur_pan_r + pan_step_r;
    end
  end

  assign cfg_t = ($signed(cfg_wdata) < spcp_pkg::TARGET_MIN)
               ? spcp_pkg::TARGET_MIN : $signed(cfg_wdata);
  assign diff  = $signed({{2{cfg_t[15]}}, cfg_t, 16'h0000})
               - $signed({{2{cur_pan_r[31]}}, cur_pan_r});

  assign div_start = cfg_we && (cfg_index == spcp_pkg::REG_TARGET)
                   && (cfg_t != target_r) && (ramp_r > 16'd1);
  assign div_abort = cfg_we && (cfg_index == spcp_pkg::REG_RAMP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_pan_r    <= '0;
      pan_step_r   <= '0;
      steps_left_r <= '0;
      target_r     <= '0;
      ramp_r       <= spcp_pkg::RAMP_RESET;
    end else begin
      // quotient lands even when a target or spare write shares the cycle; a ramp write drops it
      if (div_st.done && !div_abort) pan_step_r <= div_q;
      if (cfg_we) begin
        case (cfg_index)
          spcp_pkg::REG_TARGET: begin
            if (cfg_t != target_r) begin
              target_r <= cfg_t;
              if (ramp_r <= 16'd1) begin
                cur_pan_r    <= {cfg_t, 16'h0000};
                pan_step_r   <= '0;
                steps_left_r <= '0;
              end else begin
                steps_left_r <= ramp_r;
              end
            end
          end
          spcp_pkg::REG_RAMP: begin
            ramp_r       <= cfg_wdata;
            target_r     <= '0;
            cur_pan_r    <= '0;
            pan_step_r   <= '0;
            steps_left_r <= '0;
          end
          default: ;
        endcase
      end else if (in_fire) begin
        cur_pan_r <= pan_nxt;
        if (steps_left_r != '0) steps_left_r <= steps_left_r - 1'b1;
      end
    end
  end

  spcp_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .abort    (div_abort),
    .dividend (diff),
    .divisor  (ramp_r),
    .status   (div_st),
    .quotient (div_q)
  );

  // table index: round((pan + 1) * DEPTH / 2), capped at DEPTH
  assign pan_u    = {~pan_s1_r[31], pan_s1_r[30:0]};
  assign idx_prod = MW'(pan_u) * MW'(GAIN_TABLE_DEPTH) + MW'(33'h1_0000_0000 >> 1);
  assign idx_raw  = idx_prod[MW-1:32];
  assign idx_nxt  = (idx_raw > IDX_W'(GAIN_TABLE_DEPTH)) ? IDX_W'(GAIN_TABLE_DEPTH) : idx_raw;
  assign addr_l   = IDX_W'(GAIN_TABLE_DEPTH) - idx_s2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (adv1) v1_r <= in_fire;
      if (adv2) v2_r <= v1_r;
      if (adv3) v3_r <= v2_r;
      if (adv4) v4_r <= v3_r;
      if (adv5) v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      pan_s1_r <= pan_nxt;
      l_s1_r   <= in_ch.left_in;
      r_s1_r   <= in_ch.right_in;
    end
    if (adv2) begin
      idx_s2_r <= idx_nxt;
      l_s2_r   <= l_s1_r;
      r_s2_r   <= r_s1_r;
    end
  end

  assign lane_ctrl.en_rom = adv3;
  assign lane_ctrl.en_mul = adv4;
  assign lane_ctrl.en_out = adv5;

  // left lane takes the cosine gain, right lane the sine gain
  spcp_lane #(
    .SAMPLE_WIDTH     (SAMPLE_WIDTH),
    .GAIN_TABLE_DEPTH (GAIN_TABLE_DEPTH),
    .GAIN_WIDTH       (GAIN_WIDTH),
    .IDX_W            (IDX_W)
  ) u_lane_l (
    .clk    (clk),
    .ctrl   (lane_ctrl),
    .addr   (addr_l),
    .sample (l_s2_r),
    .result (out_ch.left_out)
  );

  spcp_lane #(
    .SAMPLE_WIDTH     (SAMPLE_WIDTH),
    .GAIN_TABLE_DEPTH (GAIN_TABLE_DEPTH),
    .GAIN_WIDTH       (GAIN_WIDTH),
    .IDX_W            (IDX_W)
  ) u_lane_r (
    .clk    (clk),
    .ctrl   (lane_ctrl),
    .addr   (idx_s2_r),
    .sample (r_s2_r),
    .result (out_ch.right_out)
  );

  assign out_ch.valid = v5_r;

endmodule

>>> hw/rtl/spcp_divider.sv
// ----------------------------------------------------------------------------
// spcp_divider
// Signed / unsigned restoring divider for the glide step, truncates to zero.
// ----------------------------------------------------------------------------
module spcp_divider (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic                     abort,
  input  logic signed [33:0]       dividend,
  input  logic        [15:0]       divisor,
  output spcp_pkg::div_status_t    status,
  output logic signed [31:0]       quotient
);

  typedef enum logic {ST_IDLE, ST_RUN} state_t;

  state_t                          state_r;
  logic                            done_r;
  logic [31:0]                     mag_r;
  logic [15:0]                     rem_r;
  logic [15:0]                     den_r;
  logic                            neg_r;
  logic [spcp_pkg::DIV_CNT_W-1:0]  cnt_r;

  logic [33:0] abs_dividend;
  logic [16:0] rem_sh;
  logic [16:0] rem_sub;
  logic        q_bit;

  assign abs_dividend = dividend[33] ? 34'(-dividend) : 34'(dividend);
  assign rem_sh       = {rem_r, mag_r[31]};
  assign q_bit        = rem_sh >= {1'b0, den_r};
  assign rem_sub      = rem_sh - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (abort) begin
        state_r <= ST_IDLE;
      end else if (start) begin
        state_r <= ST_RUN;
        mag_r   <= abs_dividend[31:0];
        neg_r   <= dividend[33];
        den_r   <= divisor;
        rem_r   <= '0;
        cnt_r   <= spcp_pkg::DIV_CNT_W'(spcp_pkg::DIV_STEPS - 1);
      end else begin
        case (state_r)
          ST_RUN: begin
            mag_r <= {mag_r[30:0], q_bit};
            rem_r <= q_bit ? rem_sub[15:0] : rem_sh[15:0];
            cnt_r <= cnt_r - 1'b1;
            if (cnt_r == '0) begin
              state_r <= ST_IDLE;
              done_r  <= 1'b1;
            end
          end
          default: ;
        endcase
      end
    end
  end

  assign status.busy = (state_r == ST_RUN);
  assign status.done = done_r;
  assign quotient    = neg_r ? -$signed(mag_r) : $signed(mag_r);

endmodule

>>> hw/rtl/spcp_lane.sv
// ----------------------------------------------------------------------------
// spcp_lane
// One gain lane: quarter-wave sine lookup, multiply, round and saturate.
// ----------------------------------------------------------------------------
module spcp_lane #(
  parameter int SAMPLE_WIDTH     = 24,
  parameter int GAIN_TABLE_DEPTH = 1024,
  parameter int GAIN_WIDTH       = 16,
  parameter int IDX_W            = $clog2(GAIN_TABLE_DEPTH + 1)
) (
  input  logic                           clk,
  input  spcp_pkg::lane_ctrl_t           ctrl,
  input  logic [IDX_W-1:0]               addr,
  input  logic signed [SAMPLE_WIDTH-1:0] sample,
  output logic signed [SAMPLE_WIDTH-1:0] result
);

  localparam int PW = SAMPLE_WIDTH + GAIN_WIDTH;

  // Taylor series of sin in Q30 through x^15, rounded to Q1.(GAIN_WIDTH-1)
  function automatic logic [GAIN_WIDTH-1:0] sine_gain(input int unsigned k);
    logic [63:0]        x;
    logic [63:0]        t;
    logic signed [63:0] sum;
    logic signed [63:0] g;
    logic signed [63:0] top;
    x   = (64'(k) * spcp_pkg::HALF_PI_Q30) / 64'(GAIN_TABLE_DEPTH);
    t   = x;
    sum = $signed(x);
    top = (64'sd1 <<< (GAIN_WIDTH - 1)) - 64'sd1;
    for (int n = 1; n <= 7; n++) begin
      t = (t * x) >> 30;
      t = (t * x) >> 30;
      // term n is divided by (2n)(2n+1)
      case (n)
        1:       t = t / 64'd6;
        2:       t = t / 64'd20;
        3:       t = t / 64'd42;
        4:       t = t / 64'd72;
        5:       t = t / 64'd110;
        6:       t = t / 64'd156;
        default: t = t / 64'd210;
      endcase
      if ((n & 1) == 1) sum = sum - $signed(t);
      else              sum = sum + $signed(t);
    end
    if (sum < 0) sum = 0;
    g = ((sum <<< (GAIN_WIDTH - 1)) + (64'sd1 <<< 29)) >>> 30;
    if (g > top) g = top;
    return g[GAIN_WIDTH-1:0];
  endfunction

  logic [GAIN_WIDTH-1:0] rom [GAIN_TABLE_DEPTH+1];

  for (genvar k = 0; k <= GAIN_TABLE_DEPTH; k++) begin : g_rom
    assign rom[k] = sine_gain(k);
  end

  logic        [GAIN_WIDTH-1:0]   gain_r;
  logic signed [SAMPLE_WIDTH-1:0] smp_r;
  logic signed [PW-1:0]           prod_r;
  logic signed [SAMPLE_WIDTH-1:0] out_r;

  logic signed [GAIN_WIDTH:0]     gain_s;
  logic signed [PW:0]             prod_full;
  logic signed [PW-1:0]           rnd;
  logic signed [SAMPLE_WIDTH:0]   shr;
  logic signed [SAMPLE_WIDTH-1:0] sat_nxt;

  assign gain_s    = {1'b0, gain_r};
  assign prod_full = smp_r * gain_s;
  assign rnd       = prod_r + (PW'(1) <<< (GAIN_WIDTH - 2));
  assign shr       = (SAMPLE_WIDTH + 1)'(rnd >>> (GAIN_WIDTH - 1));

  always_comb begin
    if (shr[SAMPLE_WIDTH] != shr[SAMPLE_WIDTH-1]) begin
      sat_nxt = shr[SAMPLE_WIDTH]
              ? {1'b1, {(SAMPLE_WIDTH-1){1'b0}}}
              : {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    end else begin
      sat_nxt = shr[SAMPLE_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.en_rom) begin
      gain_r <= rom[addr];
      smp_r  <= sample;
    end
    if (ctrl.en_mul) prod_r <= prod_full[PW-1:0];
    if (ctrl.en_out) out_r  <= sat_nxt;
  end

  assign result = out_r;

endmodule

>>> test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for smoothed_constant_power_panner_unit. Every accepted
// stereo item goes through a local model of the pan glide, the quarter-wave
// gain table and the round/saturate gain stage. The expected pair is queued
// and checked in order against out_ch. Register writes happen only while the
// pipeline is empty. Directed cases come first, then randomized phases.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SW    = 24;
  localparam int DEPTH = 1024;
  localparam int GW    = 16;

  // indexes the block does not decode
  localparam logic [spcp_pkg::CFG_INDEX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [spcp_pkg::CFG_INDEX_W-1:0] REG_SPARE_B = 2'd3;

  localparam int PAUSE_CYCLES = 40;   // lets the divider finish after a target write
  localparam int TAIL_CYCLES  = 20;
  localparam int STALL_LIMIT  = 4000;
  localparam int RANDOM_ITEMS = 1550;
  localparam int CALM_AFTER   = 1400;

  localparam logic signed [SW-1:0] S_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] S_MIN = {1'b1, {(SW-1){1'b0}}};

  typedef struct packed {
    logic signed [SW-1:0] left;
    logic signed [SW-1:0] right;
  } stereo_t;

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             cfg_we = 1'b0;
  logic [spcp_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [spcp_pkg::CFG_DATA_W-1:0]  cfg_wdata = '0;

  spcp_in_if  #(.SAMPLE_WIDTH(SW)) in_ch ();
  spcp_out_if #(.SAMPLE_WIDTH(SW)) out_ch ();

  smoothed_constant_power_panner_unit #(
    .SAMPLE_WIDTH(SW),
    .GAIN_TABLE_DEPTH(DEPTH),
    .GAIN_WIDTH(GW)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #6 clk = ~clk;

  // pan model state
  int          sine_rom [0:DEPTH];
  int          held_target;
  logic [15:0] ramp_len;
  int          pan_pos;      // Q1.31
  int          pan_step;
  int          glide_left;

  stereo_t pending_pairs[$];
  stereo_t expected_pairs[$];

  int mismatches = 0;
  int idle_cycles = 0;
  int gap_left = 0;
  int stall_left = 0;
  int gap_pct = 0;
  int stall_pct = 0;

  function automatic void build_sine_rom();
    logic [63:0] x;
    logic [63:0] t;
    longint      acc;
    longint      g;
    for (int k = 0; k <= DEPTH; k++) begin
      x = (64'(k) * spcp_pkg::HALF_PI_Q30) / 64'(DEPTH);
      t = x;
      acc = longint'(x);
      // Taylor series in Q30, truncating at every step
      for (int n = 1; n <= 7; n++) begin
        t = (t * x) >> 30;
        t = (t * x) >> 30;
        t = t / 64'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) acc -= longint'(t);
        else acc += longint'(t);
      end
      if (acc < 0) acc = 0;
      g = (acc * (longint'(1) << (GW - 1)) + (longint'(1) << 29)) >>> 30;
      if (g > (longint'(1) << (GW - 1)) - 1) g = (longint'(1) << (GW - 1)) - 1;
      sine_rom[k] = int'(g);
    end
  endfunction

  function automatic void reset_pan_model();
    held_target = 0;
    ramp_len = spcp_pkg::RAMP_RESET;
    pan_pos = 0;
    pan_step = 0;
    glide_left = 0;
  endfunction

  function automatic void apply_cfg(logic [spcp_pkg::CFG_INDEX_W-1:0] idx,
                                    logic [spcp_pkg::CFG_DATA_W-1:0] data);
    int     t;
    longint diff;
    if (idx == spcp_pkg::REG_TARGET) begin
      t = int'(signed'(data[15:0]));
      if (t < int'(spcp_pkg::TARGET_MIN)) t = int'(spcp_pkg::TARGET_MIN);
      if (t == held_target) return;   // glide in progress keeps going
      held_target = t;
      if (ramp_len <= 16'd1) begin
        pan_pos = t * 65536;
        pan_step = 0;
        glide_left = 0;
      end else begin
        diff = longint'(t) * 65536 - longint'(pan_pos);
        pan_step = int'(diff / longint'(ramp_len));   // truncates toward zero
        glide_left = int'(ramp_len);
      end
    end else if (idx == spcp_pkg::REG_RAMP) begin
      ramp_len = data[15:0];
      held_target = 0;
      pan_pos = 0;
      pan_step = 0;
      glide_left = 0;
    end
  endfunction

  function automatic logic signed [SW-1:0] scale_by_gain(logic signed [SW-1:0] x, int gain);
    longint prod;
    longint hi;
    longint lo;
    prod = longint'(x) * gain + (longint'(1) << (GW - 2));
    prod = prod >>> (GW - 1);
    hi = (longint'(1) << (SW - 1)) - 1;
    lo = -hi - 1;
    if (prod > hi) prod = hi;
    if (prod < lo) prod = lo;
    return prod[SW-1:0];
  endfunction

  function automatic stereo_t pan_and_scale(stereo_t smp);
    logic [63:0] biased;
    logic [63:0] idx;
    stereo_t     r;
    if (glide_left > 0) begin
      glide_left--;
      if (glide_left == 0) pan_pos = held_target * 65536;   // land exactly
      else pan_pos = pan_pos + pan_step;
    end
    biased = longint'(pan_pos) + 64'sd2147483648;
    idx = (biased * 64'(DEPTH) + 64'd2147483648) >> 32;
    if (idx > 64'(DEPTH)) idx = 64'(DEPTH);
    r.left  = scale_by_gain(smp.left, sine_rom[DEPTH - int'(idx)]);
    r.right = scale_by_gain(smp.right, sine_rom[int'(idx)]);
    return r;
  endfunction

  function automatic logic signed [SW-1:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return S_MAX;
      1: return S_MIN;
      2: return SW'(int'($urandom_range(0, 64)) - 32);
      default: return SW'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_ramp();
    case ($urandom_range(0, 9))
      0: return 16'd0;
      1: return 16'd1;
      2: return 16'hFFFF;
      3: return 16'($urandom);
      default: return 16'($urandom_range(2, 60));
    endcase
  endfunction

  function automatic logic [15:0] pick_target();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h8001;
      2: return 16'h7FFF;
      3: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic queue_pair(logic signed [SW-1:0] l, logic signed [SW-1:0] r);
    stereo_t p;
    p.left = l;
    p.right = r;
    pending_pairs.push_back(p);
  endtask

  task automatic wait_idle();
    while (pending_pairs.size() != 0 || expected_pairs.size() != 0 || in_ch.valid)
      @(posedge clk);
  endtask

  task automatic write_reg(logic [spcp_pkg::CFG_INDEX_W-1:0] idx,
                           logic [spcp_pkg::CFG_DATA_W-1:0] data);
    wait_idle();
    repeat (PAUSE_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    apply_cfg(idx, data);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // sample source
  always @(posedge clk) begin
    stereo_t nxt;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        nxt.left = in_ch.left_in;
        nxt.right = in_ch.right_in;
        expected_pairs.push_back(pan_and_scale(nxt));
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_ch.valid <= 1'b0;
        end else if (pending_pairs.size() != 0) begin
          nxt = pending_pairs.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.left_in <= nxt.left;
          in_ch.right_in <= nxt.right;
          if ($urandom_range(0, 99) < gap_pct) gap_left = $urandom_range(1, 16);
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result sink and checker
  always @(posedge clk) begin
    stereo_t got;
    stereo_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got.left = out_ch.left_out;
        got.right = out_ch.right_out;
        if (expected_pairs.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected item: left_out=%0d right_out=%0d", got.left, got.right);
        end else begin
          want = expected_pairs.pop_front();
          if (got.left != want.left || got.right != want.right) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: left_out exp %0d got %0d, right_out exp %0d got %0d",
                       want.left, got.left, want.right, got.right);
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if ($urandom_range(0, 99) < stall_pct) stall_left = $urandom_range(1, 16);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (idle_cycles >= STALL_LIMIT);
    $display("tb: failure");
    $finish;
  end

  initial begin
    int          sent_random;
    int          n_items;
    logic [15:0] far_left;
    in_ch.valid = 1'b0;
    in_ch.left_in = '0;
    in_ch.right_in = '0;
    out_ch.ready = 1'b0;
    sent_random = 0;
    far_left = -16'sd20000;
    build_sine_rom();
    reset_pan_model();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings, centered pan, field extremes
    queue_pair(S_MAX, S_MIN);
    queue_pair(S_MIN, S_MAX);
    queue_pair('0, '0);
    queue_pair(SW'(1), -SW'(1));
    queue_pair(-SW'(1), SW'(1));

    // zero-length ramp: hard right, then most negative code (clamped)
    write_reg(spcp_pkg::REG_RAMP, 16'd0);
    write_reg(spcp_pkg::REG_TARGET, 16'h7FFF);
    queue_pair(S_MAX, S_MAX);
    queue_pair(S_MIN, S_MIN);
    write_reg(spcp_pkg::REG_TARGET, 16'h8000);
    queue_pair(S_MAX, S_MAX);
    queue_pair(S_MIN, S_MIN);

    // short glides where the step does not divide evenly, both directions
    write_reg(spcp_pkg::REG_RAMP, 16'd3);
    write_reg(spcp_pkg::REG_TARGET, 16'd1);
    repeat (4) queue_pair(rand_sample(), rand_sample());
    write_reg(spcp_pkg::REG_TARGET, 16'hFFFF);
    repeat (3) queue_pair(rand_sample(), rand_sample());

    // rewriting the held target mid-glide leaves the glide alone
    write_reg(spcp_pkg::REG_RAMP, 16'd5);
    write_reg(spcp_pkg::REG_TARGET, far_left);
    repeat (2) queue_pair(rand_sample(), rand_sample());
    write_reg(spcp_pkg::REG_TARGET, far_left);
    repeat (3) queue_pair(rand_sample(), rand_sample());

    write_reg(REG_SPARE_A, 16'($urandom));
    write_reg(REG_SPARE_B, 16'($urandom));
    queue_pair(rand_sample(), rand_sample());

    // ramp of one jumps at once
    write_reg(spcp_pkg::REG_RAMP, 16'd1);
    write_reg(spcp_pkg::REG_TARGET, 16'd12345);
    repeat (2) queue_pair(rand_sample(), rand_sample());

    while (sent_random < RANDOM_ITEMS) begin
      if (sent_random >= CALM_AFTER) begin
        gap_pct = 0;
        stall_pct = 0;
      end else begin
        case ($urandom_range(0, 3))
          0: begin gap_pct = 0;  stall_pct = 0;  end
          1: begin gap_pct = 25; stall_pct = 0;  end
          2: begin gap_pct = 0;  stall_pct = 25; end
          default: begin gap_pct = 15; stall_pct = 15; end
        endcase
      end
      if ($urandom_range(0, 3) == 0) write_reg(spcp_pkg::REG_RAMP, pick_ramp());
      if ($urandom_range(0, 9) == 0)
        write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, 16'($urandom));
      case ($urandom_range(0, 9))
        0: write_reg(spcp_pkg::REG_TARGET, held_target[15:0]);
        1: ;
        default: write_reg(spcp_pkg::REG_TARGET, pick_target());
      endcase
      n_items = $urandom_range(30, 100);
      repeat (n_items) queue_pair(rand_sample(), rand_sample());
      sent_random += n_items;
    end

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_pairs.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
